[design/mixed_radix_index_decoder_unit_assert.svh]
// Assertion macros for the mixed radix index decoder.
`ifndef MIXED_RADIX_INDEX_DECODER_UNIT_ASSERT_SVH
`define MIXED_RADIX_INDEX_DECODER_UNIT_ASSERT_SVH

// Clocked assertion, off during reset.
`define MRID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mrid assertion failed");

// A stalled output holds its value.
`define MRID_ASSERT_HOLD(lbl, vld, rdy, sig) \
  `MRID_ASSERT(lbl, (vld && !rdy) |=> $stable(sig))

`endif

[design/mrid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mrid_pkg;

  localparam int NumDims  = 4;
  localparam int NumW     = 48;
  localparam int SizeW    = 13;
  localparam int CoordW   = 12;
  localparam int SpaceW   = 49;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;
  localparam int ProdW    = SpaceW + SizeW;

  localparam logic [SizeW-1:0]  SizeMax  = SizeW'(4096);
  localparam logic [SpaceW-1:0] SpaceMax = {SpaceW{1'b1}};

  typedef struct packed {
    logic [NumW-1:0]   n;
    logic [CoordW-1:0] r;
  } div_t;

  // One restoring division step: next quotient bit shifts into n.
  function automatic div_t div_step(div_t x, logic [SizeW-1:0] s);
    logic [SizeW-1:0] t;
    div_t             y;
    t = {x.r, x.n[NumW-1]};
    y = x;
    if (s != '0) begin
      if (t >= s) begin
        y.r = CoordW'(t - s);
        y.n = {x.n[NumW-2:0], 1'b1};
      end else begin
        y.r = t[CoordW-1:0];
        y.n = {x.n[NumW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

endpackage

`default_nettype wire

[design/mrid_dim.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrid_dim #(
  parameter int Dim = 0
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         en_i,
  input  wire logic [mrid_pkg::SizeW-1:0]                   size_i,
  input  wire logic                                         valid_i,
  input  wire logic [mrid_pkg::NumW-1:0]                    num_i,
  input  wire logic [mrid_pkg::NumDims*mrid_pkg::CoordW-1:0] coord_i,
  input  wire logic [mrid_pkg::NumDims-1:0]                 present_i,
  input  wire logic [mrid_pkg::SpaceW-1:0]                  space_i,
  output logic                                              valid_o,
  output logic [mrid_pkg::NumW-1:0]                         num_o,
  output logic [mrid_pkg::NumDims*mrid_pkg::CoordW-1:0]     coord_o,
  output logic [mrid_pkg::NumDims-1:0]                      present_o,
  output logic [mrid_pkg::SpaceW-1:0]                       space_o
);
  import mrid_pkg::*;

  localparam int Steps = NumW;

  logic                         v_q     [Steps];
  div_t                         d_q     [Steps];
  logic [NumDims*CoordW-1:0]    coord_q [Steps];
  logic [NumDims-1:0]           pres_q  [Steps];
  logic [SpaceW-1:0]            space_q [Steps];

  logic [SizeW-1:0]  factor;
  logic [ProdW-1:0]  prod;
  logic [SpaceW-1:0] space_d;
  div_t              d0_in;

  assign factor  = (size_i == '0) ? SizeW'(1) : size_i;
  assign prod    = {{SizeW{1'b0}}, space_i} * {{SpaceW{1'b0}}, factor};
  assign space_d = (prod > ProdW'(SpaceMax)) ? SpaceMax : prod[SpaceW-1:0];
  assign d0_in   = '{n: num_i, r: '0};

  for (genvar j = 0; j < Steps; j++) begin : g_step
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[j] <= 1'b0;
        end else if (en_i) begin
          v_q[j] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          d_q[j]     <= div_step(d0_in, size_i);
          coord_q[j] <= coord_i;
          pres_q[j]  <= present_i;
          space_q[j] <= space_d;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[j] <= 1'b0;
        end else if (en_i) begin
          v_q[j] <= v_q[j-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          d_q[j]     <= div_step(d_q[j-1], size_i);
          coord_q[j] <= coord_q[j-1];
          pres_q[j]  <= pres_q[j-1];
          space_q[j] <= space_q[j-1];
        end
      end
    end
  end

  always_comb begin
    valid_o   = v_q[Steps-1];
    num_o     = d_q[Steps-1].n;
    space_o   = space_q[Steps-1];
    coord_o   = coord_q[Steps-1];
    present_o = pres_q[Steps-1];
    coord_o[Dim*CoordW +: CoordW] = (size_i != '0) ? d_q[Steps-1].r : '0;
    present_o[Dim]                = (size_i != '0);
  end

endmodule

`default_nettype wire

[design/mixed_radix_index_decoder_unit.sv]
// Channel | Direction | Signals
// in      | input     | in_valid_i, in_ready_o, combination_number_i
// out     | output    | out_valid_o, out_ready_i, coord_*_o, present_*_o, space_size_o
// cfg     | input     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
// One transaction per cycle while out is not stalled, one restoring division
// bit per stage. Reset clears stage valids and sizes.
// A stall on out freezes the whole pipeline; in_ready_o falls with it.
// cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module mixed_radix_index_decoder_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mrid_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [mrid_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [mrid_pkg::NumW-1:0]      combination_number_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [mrid_pkg::CoordW-1:0]         coord_0_o,
  output logic [mrid_pkg::CoordW-1:0]         coord_1_o,
  output logic [mrid_pkg::CoordW-1:0]         coord_2_o,
  output logic [mrid_pkg::CoordW-1:0]         coord_3_o,
  output logic                                present_0_o,
  output logic                                present_1_o,
  output logic                                present_2_o,
  output logic                                present_3_o,
  output logic [mrid_pkg::SpaceW-1:0]         space_size_o
);
  import mrid_pkg::*;

  logic [SizeW-1:0] size_q [NumDims];
  logic [SizeW-1:0] eff    [NumDims];
  logic             en;

  logic                      v_c     [NumDims+1];
  logic [NumW-1:0]           n_c     [NumDims+1];
  logic [NumDims*CoordW-1:0] coord_c [NumDims+1];
  logic [NumDims-1:0]        pres_c  [NumDims+1];
  logic [SpaceW-1:0]         space_c [NumDims+1];

  assign cfg_ready_o = 1'b1;
  assign en          = !v_c[NumDims] || out_ready_i;
  assign in_ready_o  = en;

  for (genvar k = 0; k < NumDims; k++) begin : g_cfg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        size_q[k] <= '0;
      end else if (cfg_valid_i && cfg_index_i == CfgIdxW'(k)) begin
        size_q[k] <= cfg_data_i[SizeW-1:0];
      end
    end
    assign eff[k] = (size_q[k] > SizeMax) ? SizeMax : size_q[k];
  end

  assign v_c[0]     = in_valid_i;
  assign n_c[0]     = combination_number_i;
  assign coord_c[0] = '0;
  assign pres_c[0]  = '0;
  assign space_c[0] = SpaceW'(1);

  for (genvar k = 0; k < NumDims; k++) begin : g_dim
    mrid_dim #(.Dim(k)) u_dim (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .size_i    (eff[k]),
      .valid_i   (v_c[k]),
      .num_i     (n_c[k]),
      .coord_i   (coord_c[k]),
      .present_i (pres_c[k]),
      .space_i   (space_c[k]),
      .valid_o   (v_c[k+1]),
      .num_o     (n_c[k+1]),
      .coord_o   (coord_c[k+1]),
      .present_o (pres_c[k+1]),
      .space_o   (space_c[k+1])
    );
  end

  assign out_valid_o  = v_c[NumDims];
  assign coord_0_o    = coord_c[NumDims][0*CoordW +: CoordW];
  assign coord_1_o    = coord_c[NumDims][1*CoordW +: CoordW];
  assign coord_2_o    = coord_c[NumDims][2*CoordW +: CoordW];
  assign coord_3_o    = coord_c[NumDims][3*CoordW +: CoordW];
  assign present_0_o  = pres_c[NumDims][0];
  assign present_1_o  = pres_c[NumDims][1];
  assign present_2_o  = pres_c[NumDims][2];
  assign present_3_o  = pres_c[NumDims][3];
  assign space_size_o = space_c[NumDims];

endmodule

`default_nettype wire

[design/mrid_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "mixed_radix_index_decoder_unit_assert.svh"

module mrid_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [mrid_pkg::CoordW-1:0]   coord_0_o,
  input wire logic                          present_0_o,
  input wire logic [mrid_pkg::SpaceW-1:0]   space_size_o
);
  import mrid_pkg::*;

  `MRID_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, space_size_o)
  `MRID_ASSERT(a_absent_zero, (out_valid_o && !present_0_o) |-> (coord_0_o == '0))
  `MRID_ASSERT(a_space_nonzero, out_valid_o |-> (space_size_o != '0))
  `MRID_ASSERT(a_ready_stall, !in_ready_o |-> (out_valid_o && !out_ready_i))

endmodule

bind mixed_radix_index_decoder_unit mrid_checker u_mrid_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .coord_0_o    (coord_0_o),
  .present_0_o  (present_0_o),
  .space_size_o (space_size_o)
);

`default_nettype wire
